[rtl/core/greedy_permutation_code_filter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the permutation code filter
// Implication checks, same cycle and next cycle, on clock with reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_PERMUTATION_CODE_FILTER_TOP_ASSERT_SVH
`define GREEDY_PERMUTATION_CODE_FILTER_TOP_ASSERT_SVH

// cond implies expr in the same cycle
`define GPCF_ASSERT_IMPLIES(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// cond implies expr in the next cycle
`define GPCF_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

[rtl/core/gpcf_pkg.sv]
// ----------------------------------------------------------------------------
// gpcf_pkg
// Shared constants, types and helpers of the permutation code filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcf_pkg;

   localparam int GPCF_MAX_LEN  = 18;
   localparam int GPCF_CAPACITY = 1024;
   localparam int SYM_W         = 5;
   localparam int SEQ_W         = 5;
   localparam int DIST_W        = 6;
   localparam int SIZE_W        = 11;
   localparam int STAT_CNT_W    = 17;
   localparam int CSR_DATA_W    = 6;

   localparam logic [SEQ_W-1:0]  SEQ_LENGTH_RESET   = 5'd13;
   localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 6'd14;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic {
      CSR_SEQ_LENGTH   = 1'b0,
      CSR_MIN_DISTANCE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq_length;
      logic [DIST_W-1:0] min_distance;
   } cfg_type;

   typedef struct packed {
      logic                  idle;
      logic [STAT_CNT_W-1:0] count;
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_DECIDE,
      BK_WRITE,
      BK_RESP
   } back_state_type;

   // length saturated to 1..max_len
   function automatic logic [5:0] eff_len(input logic [SEQ_W-1:0] seq,
                                          input logic [5:0] max_len);
      logic [5:0] s;
      s = {1'b0, seq};
      if (s == 6'd0) s = 6'd1;
      if (s > max_len) s = max_len;
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/core/gpcf_if.sv]
// ----------------------------------------------------------------------------
// gpcf_if
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpcf_req_if import gpcf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [SYM_W-1:0] symbol;
   logic             last_symbol;

   modport source(output valid, operation, symbol, last_symbol, input ready);
   modport sink(input valid, operation, symbol, last_symbol, output ready);
endinterface

interface gpcf_rsp_if import gpcf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [SIZE_W-1:0] code_size;
   logic              store_full;

   modport source(output valid, accepted, code_size, store_full, input ready);
   modport sink(input valid, accepted, code_size, store_full, output ready);
endinterface

`default_nettype wire

[rtl/core/greedy_permutation_code_filter_top.sv]
// A non-final symbol gives no response; a clear answers from BK_RESP. A final symbol
// answers after a scan of code_size stored codewords of L symbols (none with an empty code)
// and, when stored, a row write of MAX_LEN symbols (L = effective length, one stored symbol
// read per cycle from the code store port feeding the systolic LCS row).
// Throughput: one symbol per cycle while the two entry job queue has room; one evaluation
// at a time in the back end. Reset clears control and the code count, not the code store.
// ----------------------------------------------------------------------------
// greedy_permutation_code_filter_top
// Greedy permutation code builder with LCS based distance filter.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_permutation_code_filter_top import gpcf_pkg::*; #(
   parameter int MAX_LEN  = GPCF_MAX_LEN,
   parameter int CAPACITY = GPCF_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gpcf_req_if.sink                   req_channel,
   gpcf_rsp_if.source                 rsp_channel,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int JOB_W = 1 + MAX_LEN * SYM_W;

   logic [SEQ_W-1:0]  seq_ff;
   logic [DIST_W-1:0] min_ff;
   cfg_type           cfg;
   status_type        status;

   logic                          f_valid, f_ready, f_clear;
   logic [MAX_LEN-1:0][SYM_W-1:0] f_cand;
   logic                          q_valid, q_ready;
   logic [JOB_W-1:0]              q_data;
   logic [MAX_LEN-1:0][SYM_W-1:0] q_cand;
   logic                          back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_LENGTH_RESET;
         min_ff <= MIN_DISTANCE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEQ_LENGTH:   seq_ff <= csr_write_data[SEQ_W-1:0];
            CSR_MIN_DISTANCE: min_ff <= csr_write_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.seq_length   = seq_ff;
   assign cfg.min_distance = min_ff;

   gpcf_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_channel),
      .cfg       (cfg),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job_clear (f_clear),
      .job_cand  (f_cand)
   );

   gpcf_queue #(.WIDTH(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_clear, f_cand}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_cand   = q_data[JOB_W-2:0];
   assign back_pop = q_valid && q_ready;

   gpcf_back #(.MAX_LEN(MAX_LEN), .CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job_clear (q_data[JOB_W-1]),
      .job_cand  (q_cand),
      .rsp       (rsp_channel),
      .status    (status)
   );

`include "greedy_permutation_code_filter_top_assert.svh"

   `GPCF_ASSERT_NEXT(a_clear_empties, back_pop && q_data[JOB_W-1], status.count == '0, "clear left codewords")
   `GPCF_ASSERT_IMPLIES(a_count_bound, 1'b1, status.count <= STAT_CNT_W'(CAPACITY), "count above capacity")
   `GPCF_ASSERT_NEXT(a_pop_leaves_idle, back_pop, !status.idle, "job taken but back end idle")

endmodule

`default_nettype wire

[rtl/core/gpcf_ram.sv]
// ----------------------------------------------------------------------------
// gpcf_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcf_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 18432
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/gpcf_queue.sv]
// ----------------------------------------------------------------------------
// gpcf_queue
// Two entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcf_queue #(
   parameter int WIDTH = 91
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic      [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/gpcf_front.sv]
// ----------------------------------------------------------------------------
// gpcf_front
// Collects candidate symbols and hands clear and evaluate jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcf_front import gpcf_pkg::*; #(
   parameter int MAX_LEN = GPCF_MAX_LEN
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   gpcf_req_if.sink                           req,
   input  wire cfg_type                       cfg,
   output logic                               job_valid,
   input  wire logic                          job_ready,
   output logic                               job_clear,
   output logic [MAX_LEN-1:0][SYM_W-1:0]      job_cand
);

   localparam int LW = $clog2(MAX_LEN + 1);

   logic [MAX_LEN-1:0][SYM_W-1:0] buf_ff, buf_in;
   logic [LW-1:0]                 fill_ff, fill_in;
   logic [LW-1:0]                 len;
   logic                          xfer, is_clear, room, hit;

   assign len       = LW'(eff_len(cfg.seq_length, 6'(MAX_LEN)));
   assign req.ready = job_ready;
   assign xfer      = req.valid && req.ready;
   assign is_clear  = (op_type'(req.operation) == OP_CLEAR);
   assign room      = (fill_ff < len);
   assign job_valid = req.valid && (is_clear || req.last_symbol);
   assign job_clear = is_clear;

   always_comb begin
      for (int k = 0; k < MAX_LEN; k++) begin
         hit = room && (fill_ff == LW'(k));
         job_cand[k] = hit ? req.symbol : ((LW'(k) < fill_ff) ? buf_ff[k] : '0);
         buf_in[k]   = (xfer && !is_clear && hit) ? req.symbol : buf_ff[k];
      end
      fill_in = fill_ff;
      if (xfer) begin
         if (is_clear || req.last_symbol) begin
            fill_in = '0;
         end else if (room) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

[rtl/core/gpcf_back.sv]
// ----------------------------------------------------------------------------
// gpcf_back
// Scans stored codewords through a systolic LCS row, decides and appends; also runs clears.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcf_back import gpcf_pkg::*; #(
   parameter int MAX_LEN  = GPCF_MAX_LEN,
   parameter int CAPACITY = GPCF_CAPACITY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfg_type                       cfg,
   input  wire logic                          job_valid,
   output logic                               job_ready,
   input  wire logic                          job_clear,
   input  wire logic [MAX_LEN-1:0][SYM_W-1:0] job_cand,
   gpcf_rsp_if.source                         rsp,
   output status_type                         status
);

   localparam int LW    = $clog2(MAX_LEN + 1);
   localparam int IW    = $clog2(MAX_LEN);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int DEPTH = CAPACITY * MAX_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = 7;

   back_state_type state_ff, state_in;

   logic [MAX_LEN-1:0][SYM_W-1:0] cand_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  kiss_ff, kiss_in;
   logic [CW-1:0]  done_ff, done_in;
   logic [LW-1:0]  j_ff, j_in;
   logic [AW-1:0]  base_ff, base_in;
   logic           fail_ff, fail_in;
   logic           acc_ff, acc_in;
   logic           full_ff, full_in;
   logic           iss_valid_ff, iss_valid_in;
   logic           iss_first_ff, iss_first_in;
   logic           iss_last_ff, iss_last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_acc_ff, rsp_full_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic           rsp_load, rd_en, wr_en;
   logic [AW-1:0]  addr;
   logic [SYM_W-1:0] rd_data;
   logic [LW-1:0]  len;

   // systolic row
   logic [MAX_LEN-1:0]            sv, sf, sl;
   logic [MAX_LEN-1:0][SYM_W-1:0] ss;
   logic [MAX_LEN-2:0]            stg_valid_ff, stg_first_ff, stg_last_ff;
   logic [MAX_LEN-2:0][SYM_W-1:0] stg_sym_ff;
   logic [MAX_LEN-1:0][LW-1:0]    v_ff, d_ff, nv;
   logic [LW-1:0]                 up, left, diag;
   logic [IW-1:0]                 lidx;
   logic                          res_hit, too_close;
   logic [LW-1:0]                 lcs;
   logic [DW-1:0]                 lcs_dist;

   assign len  = LW'(eff_len(cfg.seq_length, 6'(MAX_LEN)));
   assign addr = base_ff + AW'(j_ff);

   gpcf_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (cand_ff[j_ff[IW-1:0]]),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sv[0] = iss_valid_ff;
      sf[0] = iss_first_ff;
      sl[0] = iss_last_ff;
      ss[0] = rd_data;
      for (int c = 1; c < MAX_LEN; c++) begin
         sv[c] = stg_valid_ff[c-1];
         sf[c] = stg_first_ff[c-1];
         sl[c] = stg_last_ff[c-1];
         ss[c] = stg_sym_ff[c-1];
      end
      for (int c = 0; c < MAX_LEN; c++) begin
         up   = sf[c] ? '0 : v_ff[c];
         left = (c == 0) ? '0 : v_ff[(c == 0) ? 0 : c-1];
         diag = ((c == 0) || sf[c]) ? '0 : d_ff[(c == 0) ? 0 : c-1];
         if (cand_ff[c] == ss[c]) begin
            nv[c] = diag + 1'b1;
         end else begin
            nv[c] = (up > left) ? up : left;
         end
      end
      lidx      = IW'(len - 1'b1);
      res_hit   = sv[lidx] && sl[lidx];
      lcs       = nv[lidx];
      lcs_dist  = DW'({(len - lcs), 1'b0});
      too_close = (lcs_dist < DW'(cfg.min_distance));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         stg_valid_ff <= sv[MAX_LEN-2:0];
      end
   end

   always_ff @(posedge clock) begin
      stg_first_ff <= sf[MAX_LEN-2:0];
      stg_last_ff  <= sl[MAX_LEN-2:0];
      stg_sym_ff   <= ss[MAX_LEN-2:0];
      for (int c = 0; c < MAX_LEN; c++) begin
         if (sv[c]) begin
            d_ff[c] <= v_ff[c];
            v_ff[c] <= nv[c];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      kiss_in      = kiss_ff;
      j_in         = j_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      full_in      = full_ff;
      done_in      = done_ff + CW'(res_hit);
      fail_in      = fail_ff | (res_hit && too_close);
      job_ready    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      iss_valid_in = 1'b0;
      iss_first_in = 1'b0;
      iss_last_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_load     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               acc_in  = 1'b0;
               full_in = 1'b0;
               done_in = '0;
               fail_in = 1'b0;
               if (job_clear) begin
                  count_in = '0;
                  state_in = BK_RESP;
               end else begin
                  kiss_in  = '0;
                  j_in     = '0;
                  base_in  = '0;
                  state_in = (count_ff == '0) ? BK_DECIDE : BK_SCAN;
               end
            end
         end
         BK_SCAN: begin
            rd_en        = 1'b1;
            iss_valid_in = 1'b1;
            iss_first_in = (j_ff == '0);
            iss_last_in  = (j_ff == len - 1'b1);
            if (j_ff == len - 1'b1) begin
               j_in    = '0;
               base_in = base_ff + AW'(MAX_LEN);
               kiss_in = kiss_ff + 1'b1;
               if (CW'(kiss_ff + 1'b1) == count_ff) begin
                  state_in = BK_DRAIN;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         BK_DRAIN: begin
            if (done_ff == count_ff) begin
               state_in = BK_DECIDE;
            end
         end
         BK_DECIDE: begin
            if (fail_ff) begin
               state_in = BK_RESP;
            end else if (count_ff < CW'(CAPACITY)) begin
               j_in     = '0;
               state_in = BK_WRITE;
            end else begin
               full_in  = 1'b1;
               state_in = BK_RESP;
            end
         end
         BK_WRITE: begin
            wr_en = 1'b1;
            if (j_ff == LW'(MAX_LEN - 1)) begin
               count_in = count_ff + 1'b1;
               acc_in   = 1'b1;
               j_in     = '0;
               state_in = BK_RESP;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         BK_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         kiss_ff      <= '0;
         done_ff      <= '0;
         j_ff         <= '0;
         base_ff      <= '0;
         fail_ff      <= 1'b0;
         acc_ff       <= 1'b0;
         full_ff      <= 1'b0;
         iss_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         kiss_ff      <= kiss_in;
         done_ff      <= done_in;
         j_ff         <= j_in;
         base_ff      <= base_in;
         fail_ff      <= fail_in;
         acc_ff       <= acc_in;
         full_ff      <= full_in;
         iss_valid_ff <= iss_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_first_ff <= iss_first_in;
      iss_last_ff  <= iss_last_in;
      if (state_ff == BK_IDLE && job_valid) begin
         cand_ff <= job_cand;
      end
      if (rsp_load) begin
         rsp_acc_ff  <= acc_ff;
         rsp_full_ff <= full_ff;
         rsp_size_ff <= SIZE_W'(count_ff);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.accepted   = rsp_acc_ff;
   assign rsp.store_full = rsp_full_ff;
   assign rsp.code_size  = rsp_size_ff;

   assign status.idle  = (state_ff == BK_IDLE);
   assign status.count = STAT_CNT_W'(count_ff);

endmodule

`default_nettype wire
